// ----- rtl/gtq_pkg.sv -----
// ============================================================================
// gtq_pkg
// Shared widths, request codes, error codes and controller states of the
// grouped team queue.
// ============================================================================
package gtq_pkg;

    // Fixed payload widths of the request and response channels
    localparam int GROUP_W = 6;
    localparam int TAG_W   = 16;
    localparam int ERR_W   = 2;

    // Request operation
    typedef enum logic [0:0] {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    // Response error codes
    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DEC,
        S_SRV,
        S_GRP,
        S_HEAD,
        S_FIN
    } t_state;

endpackage

// ----- rtl/gtq_req_if.sv -----
// ============================================================================
// gtq_req_if
// Request channel: valid/ready handshake carrying op, group and tag.
// ============================================================================
interface gtq_req_if import gtq_pkg::*; ();

    logic               valid;
    logic               ready;
    logic               op;
    logic [GROUP_W-1:0] group;
    logic [TAG_W-1:0]   tag;

    modport source (output valid, op, group, tag, input ready);
    modport sink   (input valid, op, group, tag, output ready);

endinterface

// ----- rtl/gtq_rsp_if.sv -----
// ============================================================================
// gtq_rsp_if
// Response channel: valid/ready handshake carrying the result of one request.
// ============================================================================
interface gtq_rsp_if import gtq_pkg::*; ();

    logic               valid;
    logic               ready;
    logic               accepted;
    logic               served;
    logic [GROUP_W-1:0] served_group;
    logic [TAG_W-1:0]   served_tag;
    logic [ERR_W-1:0]   error;

    modport source (output valid, accepted, served, served_group, served_tag, error,
                    input ready);
    modport sink   (input valid, accepted, served, served_group, served_tag, error,
                    output ready);

endinterface

// ----- rtl/gtq_ram.sv -----
// ============================================================================
// gtq_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module gtq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/grouped_team_queue_core.sv -----
// ============================================================================
// grouped_team_queue_core
// Team queue: per-group FIFOs of tagged entries, served group by group in
// the order the groups became active.
// ============================================================================
// One request is handled at a time. An enqueue or an errored request goes
// through decode back to idle; a dequeue walks group, head and finish; an
// enqueue that also triggers an auto serve walks decode, serve, group, head
// and finish. The steps follow the registered RAM reads a serve walks:
// active list, then group table, then the slot's tag and link. After reset
// a clearing pass marks every group empty; requests are held off during it,
// configuration writes are taken. A finished response sits in an output
// register, so the next request is accepted while it waits; the controller
// only holds when a second response is ready before the first is taken.
// ============================================================================
module grouped_team_queue_core import gtq_pkg::*; #(
    parameter int ENTRIES = 1024,
    parameter int GROUPS  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    gtq_req_if.sink     i_req,
    gtq_rsp_if.source   o_rsp
);

    localparam int AW  = $clog2(ENTRIES);
    localparam int GW  = $clog2(GROUPS);
    localparam int FCW = AW + 1;
    localparam int CW  = GW + 1;

    localparam logic [FCW-1:0] FC_FULL = FCW'(ENTRIES);
    localparam logic [GW-1:0]  G_LAST  = GW'(GROUPS - 1);

    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_ODD  = 2'd1;
    localparam logic [1:0] PH_EVEN = 2'd2;

    typedef struct packed {
        logic          busy;
        logic [AW-1:0] head;
        logic [AW-1:0] tail;
    } t_grp_ent;

    // Control state
    t_state             r_state, n_state;
    t_op                r_op;
    logic [GW-1:0]      r_group;
    logic [TAG_W-1:0]   r_tag;
    logic [FCW-1:0]     r_fc, n_fc;
    logic [FCW-1:0]     r_low, n_low;
    logic [GW-1:0]      r_rd, n_rd;
    logic [GW-1:0]      r_wr, n_wr;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [1:0]         r_phase, n_phase;
    logic               r_auto;
    logic [GW-1:0]      r_clr, n_clr;
    logic [GW-1:0]      r_sg, n_sg;
    logic [AW-1:0]      r_head, n_head;
    logic [AW-1:0]      r_tail, n_tail;

    // Response register
    logic               r_out_valid, n_out_valid;
    logic               r_out_acc, n_out_acc;
    logic               r_out_srv, n_out_srv;
    logic [GROUP_W-1:0] r_out_sg, n_out_sg;
    logic [TAG_W-1:0]   r_out_tag, n_out_tag;
    logic [ERR_W-1:0]   r_out_err, n_out_err;

    // RAM ports
    logic               tag_we;
    logic [AW-1:0]      tag_waddr, tag_raddr;
    logic [TAG_W-1:0]   tag_wdata, tag_q;
    logic               link_we;
    logic [AW-1:0]      link_waddr, link_raddr, link_wdata, link_q;
    logic               free_we;
    logic [AW-1:0]      free_waddr, free_raddr, free_wdata, free_q;
    logic               grp_we;
    logic [GW-1:0]      grp_waddr, grp_raddr;
    t_grp_ent           grp_wdata, grp_q;
    logic               act_we;
    logic [GW-1:0]      act_waddr, act_wdata, act_q;

    logic [GW-1:0]      in_grp;
    logic [FCW-1:0]     fc_m1;
    logic [AW-1:0]      slot;
    logic               out_free;

    // Reduce the request group modulo GROUPS through a small table
    always_comb begin
        in_grp = '0;
        for (int i = 0; i < 2**GROUP_W; i++) begin
            if (i_req.group == GROUP_W'(i)) begin
                in_grp = GW'(i % GROUPS);
            end
        end
    end

    // Top of the free stack; slots below the low-water mark were never pushed
    assign fc_m1      = r_fc - FCW'(1);
    assign free_raddr = fc_m1[AW-1:0];
    assign slot       = (fc_m1 < r_low) ? fc_m1[AW-1:0] : free_q;

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // Next state, RAM accesses and response
    always_comb begin
        n_state     = r_state;
        n_fc        = r_fc;
        n_low       = r_low;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_cnt       = r_cnt;
        n_phase     = r_phase;
        n_clr       = r_clr;
        n_sg        = r_sg;
        n_head      = r_head;
        n_tail      = r_tail;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_acc   = r_out_acc;
        n_out_srv   = r_out_srv;
        n_out_sg    = r_out_sg;
        n_out_tag   = r_out_tag;
        n_out_err   = r_out_err;

        tag_we      = 1'b0;
        tag_waddr   = slot;
        tag_wdata   = r_tag;
        tag_raddr   = (r_state == S_HEAD) ? grp_q.head : r_head;
        link_we     = 1'b0;
        link_waddr  = grp_q.tail;
        link_wdata  = slot;
        link_raddr  = (r_state == S_HEAD) ? grp_q.head : r_head;
        free_we     = 1'b0;
        free_waddr  = r_fc[AW-1:0];
        free_wdata  = r_head;
        grp_we      = 1'b0;
        grp_waddr   = r_group;
        grp_wdata   = '0;
        act_we      = 1'b0;
        act_waddr   = r_wr;
        act_wdata   = r_group;

        // Group table read address follows the step in progress
        if (r_state == S_IDLE) begin
            grp_raddr = in_grp;
        end else if (r_state == S_GRP) begin
            grp_raddr = act_q;
        end else begin
            grp_raddr = r_group;
        end

        unique case (r_state)
            S_CLEAR: begin
                // Mark every group empty, one per cycle
                grp_we    = 1'b1;
                grp_waddr = r_clr;
                grp_wdata = '0;
                if (r_clr == G_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + GW'(1);
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    if (t_op'(i_req.op) == OP_DEQ && r_cnt != '0) begin
                        n_state = S_GRP;
                    end else begin
                        n_state = S_DEC;
                    end
                end
            end
            S_DEC: begin
                if (out_free) begin
                    priority if (r_op == OP_DEQ) begin
                        // Dequeue with nothing queued
                        n_out_valid = 1'b1;
                        n_out_acc   = 1'b0;
                        n_out_srv   = 1'b0;
                        n_out_sg    = '0;
                        n_out_tag   = '0;
                        n_out_err   = ERR_EMPTY;
                        n_state     = S_IDLE;
                    end else if (r_fc == '0) begin
                        // Enqueue with no free slot
                        n_out_valid = 1'b1;
                        n_out_acc   = 1'b0;
                        n_out_srv   = 1'b0;
                        n_out_sg    = '0;
                        n_out_tag   = '0;
                        n_out_err   = ERR_FULL;
                        n_state     = S_IDLE;
                    end else begin
                        // Store the entry and link it behind its group
                        tag_we = 1'b1;
                        grp_we = 1'b1;
                        if (!grp_q.busy) begin
                            grp_wdata = '{busy: 1'b1, head: slot, tail: slot};
                            act_we    = 1'b1;
                            n_wr      = (r_wr == G_LAST) ? '0 : r_wr + GW'(1);
                            n_cnt     = r_cnt + CW'(1);
                        end else begin
                            link_we   = 1'b1;
                            grp_wdata = '{busy: 1'b1, head: grp_q.head, tail: slot};
                        end
                        n_fc    = fc_m1;
                        n_low   = (fc_m1 < r_low) ? fc_m1 : r_low;
                        n_phase = (r_phase == PH_ODD) ? PH_EVEN : PH_ODD;
                        if (r_phase == PH_EVEN && r_auto) begin
                            n_state = S_SRV;
                        end else begin
                            n_out_valid = 1'b1;
                            n_out_acc   = 1'b1;
                            n_out_srv   = 1'b0;
                            n_out_sg    = '0;
                            n_out_tag   = '0;
                            n_out_err   = ERR_NONE;
                            n_state     = S_IDLE;
                        end
                    end
                end
            end
            S_SRV: begin
                // Re-read the active list after the write of the enqueue step
                n_state = S_GRP;
            end
            S_GRP: begin
                n_sg    = act_q;
                n_state = S_HEAD;
            end
            S_HEAD: begin
                n_head  = grp_q.head;
                n_tail  = grp_q.tail;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    // Pop the head entry and return its slot
                    grp_we    = 1'b1;
                    grp_waddr = r_sg;
                    if (r_head == r_tail) begin
                        grp_wdata = '{busy: 1'b0, head: r_head, tail: r_tail};
                        n_rd      = (r_rd == G_LAST) ? '0 : r_rd + GW'(1);
                        n_cnt     = r_cnt - CW'(1);
                    end else begin
                        grp_wdata = '{busy: 1'b1, head: link_q, tail: r_tail};
                    end
                    free_we     = 1'b1;
                    n_fc        = r_fc + FCW'(1);
                    n_out_valid = 1'b1;
                    n_out_acc   = (r_op == OP_ENQ);
                    n_out_srv   = 1'b1;
                    n_out_sg    = GROUP_W'(r_sg);
                    n_out_tag   = tag_q;
                    n_out_err   = ERR_NONE;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_fc        <= FC_FULL;
            r_low       <= FC_FULL;
            r_rd        <= '0;
            r_wr        <= '0;
            r_cnt       <= '0;
            r_phase     <= PH_NONE;
            r_auto      <= 1'b1;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fc        <= n_fc;
            r_low       <= n_low;
            r_rd        <= n_rd;
            r_wr        <= n_wr;
            r_cnt       <= n_cnt;
            r_phase     <= n_phase;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_auto <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_op    <= t_op'(i_req.op);
            r_group <= in_grp;
            r_tag   <= i_req.tag;
        end
        r_sg      <= n_sg;
        r_head    <= n_head;
        r_tail    <= n_tail;
        r_out_acc <= n_out_acc;
        r_out_srv <= n_out_srv;
        r_out_sg  <= n_out_sg;
        r_out_tag <= n_out_tag;
        r_out_err <= n_out_err;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.accepted     = r_out_acc;
    assign o_rsp.served       = r_out_srv;
    assign o_rsp.served_group = r_out_sg;
    assign o_rsp.served_tag   = r_out_tag;
    assign o_rsp.error        = r_out_err;

    // Slot tags
    gtq_ram #(.WIDTH(TAG_W), .DEPTH(ENTRIES)) u_tag_ram (
        .i_clk  (i_clk),
        .i_we   (tag_we),
        .i_waddr(tag_waddr),
        .i_wdata(tag_wdata),
        .i_raddr(tag_raddr),
        .o_rdata(tag_q)
    );

    // Slot links within a group
    gtq_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (link_we),
        .i_waddr(link_waddr),
        .i_wdata(link_wdata),
        .i_raddr(link_raddr),
        .o_rdata(link_q)
    );

    // Free slot stack
    gtq_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_free_ram (
        .i_clk  (i_clk),
        .i_we   (free_we),
        .i_waddr(free_waddr),
        .i_wdata(free_wdata),
        .i_raddr(free_raddr),
        .o_rdata(free_q)
    );

    // Group table: busy flag, head and tail slot
    gtq_ram #(.WIDTH($bits(t_grp_ent)), .DEPTH(GROUPS)) u_grp_ram (
        .i_clk  (i_clk),
        .i_we   (grp_we),
        .i_waddr(grp_waddr),
        .i_wdata(grp_wdata),
        .i_raddr(grp_raddr),
        .o_rdata(grp_q)
    );

    // Active group ring
    gtq_ram #(.WIDTH(GW), .DEPTH(GROUPS)) u_act_ram (
        .i_clk  (i_clk),
        .i_we   (act_we),
        .i_waddr(act_waddr),
        .i_wdata(act_wdata),
        .i_raddr(r_rd),
        .o_rdata(act_q)
    );

endmodule

// ----- rtl/gtq_checker.sv -----
// ============================================================================
// gtq_checker
// Port-level checks on the response channel of the grouped team queue.
// ============================================================================
module gtq_checker import gtq_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_accepted,
    input logic               i_served,
    input logic [GROUP_W-1:0] i_served_group,
    input logic [TAG_W-1:0]   i_served_tag,
    input logic [ERR_W-1:0]   i_error
);

    // Hold a stalled response
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_accepted)
            && $stable(i_served) && $stable(i_served_group)
            && $stable(i_served_tag) && $stable(i_error))
        else $error("stalled response changed");

    // Drop the response on reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("response valid after reset");

    // A flagged request neither stores nor serves
    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_error != ERR_NONE |-> !i_accepted && !i_served)
        else $error("errored request changed the queue");

    // Every response reports a store, a serve or an error
    a_some_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_accepted || i_served || i_error != ERR_NONE)
        else $error("response without effect");

    // No served entry means zero group and tag
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_served |-> i_served_group == '0 && i_served_tag == '0)
        else $error("served fields set without a serve");

endmodule

bind grouped_team_queue_core gtq_checker u_gtq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_accepted    (o_rsp.accepted),
    .i_served      (o_rsp.served),
    .i_served_group(o_rsp.served_group),
    .i_served_tag  (o_rsp.served_tag),
    .i_error       (o_rsp.error)
);
